// ===== rtl/etcb_pkg.sv =====
// Shared types and constants of the expiring ticket cache.
package etcb_pkg;

   typedef enum logic [2:0] {
      OP_LOOKUP = 3'd0,
      OP_STORE  = 3'd1,
      OP_FAIL   = 3'd2,
      OP_PROBE  = 3'd3,
      OP_CLEAR  = 3'd4
   } etcb_op_type;

   localparam logic [1:0] CSR_SERVER_SET    = 2'd0;
   localparam logic [1:0] CSR_REFRESH_MARGIN = 2'd1;
   localparam logic [1:0] CSR_FIRST_BACKOFF = 2'd2;
   localparam logic [1:0] CSR_MAX_BACKOFF   = 2'd3;

   localparam logic [31:0] REFRESH_MARGIN_RESET = 32'd60000;
   localparam logic [31:0] FIRST_BACKOFF_RESET  = 32'd1000;
   localparam logic [31:0] MAX_BACKOFF_RESET    = 32'd300000;
   localparam logic [7:0]  FAILURES_MAX         = 8'd255;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND,
      ST_EV_CHECK,
      ST_EV_SCAN,
      ST_EV_WRITE,
      ST_FREE_SCAN,
      ST_UPDATE,
      ST_BACKOFF,
      ST_RESP
   } etcb_state_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [63:0]        object_key;
      logic               key_well_formed;
      logic [47:0]        now_ms;
      logic [31:0]        ticket_id;
      logic               ticket_present;
      logic [39:0]        expiry_seconds;
      logic signed [31:0] lifetime_ms;
   } etcb_req_type;

   typedef struct packed {
      logic        ticket_valid;
      logic [31:0] out_ticket_id;
      logic [39:0] out_expiry_seconds;
      logic        mint_request;
      logic        ticket_ready;
      logic        ticket_failed;
      logic        live_now;
      logic [8:0]  entries_held;
   } etcb_rsp_type;

endpackage

// ===== rtl/etcb_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module etcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/expiring_ticket_cache_with_backoff.sv =====
// Top level of the expiring ticket cache with capped doubling retry backoff.
//
// Usage: an item is presented on req and taken at a clock edge where start is
// high and busy is low. Busy stays high until the item's single result has been
// shown on rsp for exactly one cycle, marked by rsp_valid; the receiver cannot
// hold the result off, so it must sample it in that cycle.
// Configuration registers are written through csr_we, csr_index and csr_wdata;
// the user must write them only while the block is idle, as the block itself
// does not enforce it. Each write takes effect at the clock edge. All slot
// records live in one RAM with a registered read. Every key search is a linear
// scan of that RAM, one slot per cycle. When a new key finds the table full,
// or a lookup or store leaves the count above CAPACITY, each evicted entry
// costs one more full scan for the least recently used entry not in flight.
// The clear operation and reset both run a clearing pass that writes every slot
// free, one slot a cycle; busy is high during the pass after reset, so no item
// is accepted then.
// Results for store and clear carry the occupied count after any eviction.
module expiring_ticket_cache_with_backoff
   import etcb_pkg::*;
#(
   parameter int CAPACITY    = 256,
   parameter int TICKET_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  etcb_req_type req,
   output logic         rsp_valid,
   output etcb_rsp_type rsp,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int SLOTS = CAPACITY + 1;
   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int TW    = TICKET_BITS;

   localparam logic [CW-1:0] SLOTS_C    = CW'(SLOTS);
   localparam logic [CW-1:0] CAP_C      = CW'(CAPACITY);
   localparam logic [CW-1:0] LIMIT_FULL = CW'(CAPACITY * 3 / 4 - 1);
   localparam logic [CW-1:0] LIMIT_OVER = CW'(CAPACITY * 3 / 4);
   localparam logic [AW-1:0] LAST_SLOT  = AW'(SLOTS - 1);
   localparam logic [CW-1:0] LAST_SCAN  = CW'(SLOTS - 1);

   typedef struct packed {
      logic          used;
      logic [63:0]   key;
      logic [TW-1:0] ticket;
      logic          has_ticket;
      logic [39:0]   expiry;
      logic [48:0]   deadline;
      logic [47:0]   last_used;
      logic          pending;
      logic [7:0]    failures;
      logic [48:0]   retry_after;
   } rec_type;

   etcb_state_type state_ff, state_in, ev_ret_ff, ev_ret_in;
   etcb_req_type   req_ff, req_in;
   etcb_rsp_type   rsp_ff, rsp_in;
   rec_type        cur_ff, cur_in, best_ff, best_in;
   rec_type        rd_rec, wr_rec, fresh_rec;
   logic [AW-1:0]  slot_ff, slot_in, free_idx_ff, free_idx_in;
   logic [AW-1:0]  best_idx_ff, best_idx_in, rd_idx_ff, rd_idx_in;
   logic           is_new_ff, is_new_in, free_vld_ff, free_vld_in;
   logic           best_vld_ff, best_vld_in, rd_vld_ff, rd_vld_in;
   logic           clr_item_ff, clr_item_in;
   logic [CW-1:0]  scan_ff, scan_in, count_ff, count_in, ev_limit_ff, ev_limit_in;
   logic [33:0]    bo_ff, bo_in;
   logic [7:0]     bo_cnt_ff, bo_cnt_in;
   logic           server_set_ff;
   logic [31:0]    margin_ff, first_bo_ff, max_bo_ff;

   logic           ram_we, issue;
   logic [AW-1:0]  ram_waddr;
   logic [$bits(rec_type)-1:0] ram_rdata;

   // Per-cycle helpers.
   logic           live, stale, want_mint, cand, free_here, better;
   logic [48:0]    now49, deadline_new;
   logic [30:0]    life_nn;
   logic [31:0]    backoff;

   etcb_ram #(
      .WIDTH($bits(rec_type)),
      .DEPTH(SLOTS)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_rec),
      .raddr (scan_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign rd_rec = rec_type'(ram_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ev_ret_ff     <= ST_RESP;
         scan_ff       <= '0;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         clr_item_ff   <= 1'b0;
         free_vld_ff   <= 1'b0;
         best_vld_ff   <= 1'b0;
         is_new_ff     <= 1'b0;
         ev_limit_ff   <= '0;
         server_set_ff <= 1'b0;
         margin_ff     <= REFRESH_MARGIN_RESET;
         first_bo_ff   <= FIRST_BACKOFF_RESET;
         max_bo_ff     <= MAX_BACKOFF_RESET;
      end else begin
         state_ff    <= state_in;
         ev_ret_ff   <= ev_ret_in;
         scan_ff     <= scan_in;
         count_ff    <= count_in;
         rd_vld_ff   <= rd_vld_in;
         clr_item_ff <= clr_item_in;
         free_vld_ff <= free_vld_in;
         best_vld_ff <= best_vld_in;
         is_new_ff   <= is_new_in;
         ev_limit_ff <= ev_limit_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SERVER_SET:     server_set_ff <= csr_wdata[0];
               CSR_REFRESH_MARGIN: margin_ff     <= csr_wdata;
               CSR_FIRST_BACKOFF:  first_bo_ff   <= csr_wdata;
               CSR_MAX_BACKOFF:    max_bo_ff     <= csr_wdata;
               default:            ;
            endcase
         end
      end
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      slot_ff     <= slot_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      rd_idx_ff   <= rd_idx_in;
      bo_ff       <= bo_in;
      bo_cnt_ff   <= bo_cnt_in;
   end

   always_comb begin
      state_in    = state_ff;
      ev_ret_in   = ev_ret_ff;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      slot_in     = slot_ff;
      free_idx_in = free_idx_ff;
      best_idx_in = best_idx_ff;
      is_new_in   = is_new_ff;
      free_vld_in = free_vld_ff;
      best_vld_in = best_vld_ff;
      clr_item_in = clr_item_ff;
      scan_in     = scan_ff;
      count_in    = count_ff;
      ev_limit_in = ev_limit_ff;
      bo_in       = bo_ff;
      bo_cnt_in   = bo_cnt_ff;
      ram_we      = 1'b0;
      ram_waddr   = slot_ff;
      wr_rec      = cur_ff;
      issue       = 1'b0;

      now49        = 49'(req_ff.now_ms);
      life_nn      = req_ff.lifetime_ms[31] ? 31'd0 : req_ff.lifetime_ms[30:0];
      deadline_new = now49 + 49'(life_nn);
      live         = cur_ff.has_ticket && (now49 < cur_ff.deadline);
      stale        = live && ((now49 + 49'(margin_ff)) >= cur_ff.deadline);
      want_mint    = (!live || stale) && !cur_ff.pending && (now49 >= cur_ff.retry_after);
      backoff      = (bo_ff > 34'(max_bo_ff)) ? max_bo_ff : bo_ff[31:0];

      fresh_rec      = '0;
      fresh_rec.used = 1'b1;
      fresh_rec.key  = req_ff.object_key;

      free_here = !rd_rec.used && !free_vld_ff;
      cand      = rd_rec.used && !rd_rec.pending;
      better    = cand && (!best_vld_ff || (rd_rec.last_used < best_ff.last_used));

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[AW-1:0];
            wr_rec    = '0;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == LAST_SCAN) begin
               state_in = clr_item_ff ? ST_RESP : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               req_in      = req;
               rsp_in      = '0;
               clr_item_in = 1'b0;
               free_vld_in = 1'b0;
               unique case (req.operation)
                  OP_LOOKUP: begin
                     state_in = (server_set_ff && req.key_well_formed) ? ST_FIND : ST_RESP;
                  end
                  OP_STORE, OP_FAIL, OP_PROBE: state_in = ST_FIND;
                  OP_CLEAR: begin
                     clr_item_in = 1'b1;
                     count_in    = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_FIND: begin
            issue = scan_ff < SLOTS_C;
            if (rd_vld_ff) begin
               if (free_here) begin
                  free_vld_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_rec.used && (rd_rec.key == req_ff.object_key)) begin
                  cur_in    = rd_rec;
                  slot_in   = rd_idx_ff;
                  is_new_in = 1'b0;
                  if (req_ff.operation == OP_PROBE) begin
                     rsp_in.live_now = rd_rec.has_ticket && (now49 < rd_rec.deadline);
                     state_in        = ST_RESP;
                  end else begin
                     state_in = ST_UPDATE;
                  end
               end else if (rd_idx_ff == LAST_SLOT) begin
                  if (req_ff.operation == OP_PROBE) begin
                     state_in = ST_RESP;
                  end else if (count_ff >= SLOTS_C) begin
                     ev_limit_in = LIMIT_FULL;
                     ev_ret_in   = ST_FREE_SCAN;
                     state_in    = ST_EV_CHECK;
                  end else if (free_vld_ff || free_here) begin
                     slot_in   = free_vld_ff ? free_idx_ff : rd_idx_ff;
                     cur_in    = fresh_rec;
                     is_new_in = 1'b1;
                     count_in  = count_ff + 1'b1;
                     state_in  = ST_UPDATE;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end
         end

         ST_EV_CHECK: begin
            best_vld_in = 1'b0;
            free_vld_in = 1'b0;
            state_in    = (count_ff > ev_limit_ff) ? ST_EV_SCAN : ev_ret_ff;
         end

         ST_EV_SCAN: begin
            issue = scan_ff < SLOTS_C;
            if (rd_vld_ff) begin
               if (better) begin
                  best_vld_in = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = rd_rec;
               end
               if (rd_idx_ff == LAST_SLOT) begin
                  state_in = (best_vld_ff || better) ? ST_EV_WRITE : ev_ret_ff;
               end
            end
         end

         ST_EV_WRITE: begin
            ram_we      = 1'b1;
            ram_waddr   = best_idx_ff;
            wr_rec      = best_ff;
            wr_rec.used = 1'b0;
            count_in    = count_ff - 1'b1;
            state_in    = ST_EV_CHECK;
         end

         ST_FREE_SCAN: begin
            issue = scan_ff < SLOTS_C;
            if (rd_vld_ff) begin
               if (!rd_rec.used) begin
                  slot_in   = rd_idx_ff;
                  cur_in    = fresh_rec;
                  is_new_in = 1'b1;
                  count_in  = count_ff + 1'b1;
                  state_in  = ST_UPDATE;
               end else if (rd_idx_ff == LAST_SLOT) begin
                  // No slot came free: the item is dropped.
                  state_in = ST_RESP;
               end
            end
         end

         ST_UPDATE: begin
            unique case (req_ff.operation)
               OP_LOOKUP: begin
                  ram_we           = 1'b1;
                  wr_rec.last_used = req_ff.now_ms;
                  if (is_new_ff) begin
                     wr_rec.pending      = 1'b1;
                     rsp_in.mint_request = 1'b1;
                     ev_limit_in         = LIMIT_OVER;
                     ev_ret_in           = ST_RESP;
                     state_in            = (count_ff > CAP_C) ? ST_EV_CHECK : ST_RESP;
                  end else begin
                     if (want_mint) begin
                        wr_rec.pending      = 1'b1;
                        rsp_in.mint_request = 1'b1;
                     end
                     if (live) begin
                        rsp_in.ticket_valid       = 1'b1;
                        rsp_in.out_ticket_id      = 32'(cur_ff.ticket);
                        rsp_in.out_expiry_seconds = cur_ff.expiry;
                     end
                     state_in = ST_RESP;
                  end
               end
               OP_STORE: begin
                  ram_we                    = 1'b1;
                  wr_rec.ticket             = TW'(req_ff.ticket_id);
                  wr_rec.has_ticket         = req_ff.ticket_present;
                  wr_rec.expiry             = req_ff.expiry_seconds;
                  wr_rec.deadline           = deadline_new;
                  wr_rec.last_used          = req_ff.now_ms;
                  wr_rec.pending            = 1'b0;
                  wr_rec.failures           = '0;
                  wr_rec.retry_after        = '0;
                  rsp_in.out_ticket_id      = 32'(TW'(req_ff.ticket_id));
                  rsp_in.out_expiry_seconds = req_ff.expiry_seconds;
                  rsp_in.ticket_ready       = req_ff.ticket_present && server_set_ff &&
                                              req_ff.key_well_formed;
                  ev_limit_in               = LIMIT_OVER;
                  ev_ret_in                 = ST_RESP;
                  state_in                  = (count_ff > CAP_C) ? ST_EV_CHECK : ST_RESP;
               end
               OP_FAIL: begin
                  cur_in.pending = 1'b0;
                  if (cur_ff.failures != FAILURES_MAX) begin
                     cur_in.failures = cur_ff.failures + 1'b1;
                  end
                  bo_in     = 34'(first_bo_ff);
                  bo_cnt_in = 8'd1;
                  state_in  = ST_BACKOFF;
               end
               default: state_in = ST_RESP;
            endcase
         end

         ST_BACKOFF: begin
            // One doubling per cycle until the count or the cap is reached.
            if ((bo_cnt_ff < cur_ff.failures) && (bo_ff < 34'(max_bo_ff))) begin
               bo_in     = {bo_ff[32:0], 1'b0};
               bo_cnt_in = bo_cnt_ff + 1'b1;
            end else begin
               ram_we               = 1'b1;
               wr_rec.retry_after   = now49 + 49'(backoff);
               rsp_in.ticket_failed = 1'b1;
               state_in             = ST_RESP;
            end
         end

         ST_RESP: state_in = ST_IDLE;

         default: state_in = ST_IDLE;
      endcase

      // Every scan starts from slot zero with no read in flight.
      rd_vld_in = issue && (state_in == state_ff);
      rd_idx_in = scan_ff[AW-1:0];
      if (issue) begin
         scan_in = scan_ff + 1'b1;
      end
      if (state_in != state_ff) begin
         scan_in = '0;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      rsp              = rsp_ff;
      rsp.entries_held = 9'(count_ff);
   end

   // A result is a single-cycle strobe and is followed by the idle state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe lasted more than one cycle");

   // The occupied count never exceeds the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_C)
      else $error("occupied count above slot total");

   // An accepted item always makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // The table RAM is never written while idle.
   assert property (@(posedge clock) disable iff (reset)
      !busy |-> !ram_we)
      else $error("table written while idle");

   // Store, fail and probe outcomes are mutually exclusive in one result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp.ticket_ready, rsp.ticket_failed, rsp.live_now}) <= 1)
      else $error("conflicting result flags");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the expiring ticket cache with retry backoff.
module tb_top
   import etcb_pkg::*;
;

   localparam int CAP   = 256;
   localparam int SLOTS = CAP + 1;
   localparam longint CYCLE_LIMIT = 4000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   etcb_req_type req = '0;
   logic         rsp_valid;
   etcb_rsp_type rsp;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   expiring_ticket_cache_with_backoff #(.CAPACITY(CAP), .TICKET_BITS(32)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow copy of the cache state and its registers.
   logic        cfg_server;
   logic [31:0] cfg_margin, cfg_first, cfg_max;
   logic        sh_used [SLOTS];
   logic [63:0] sh_key [SLOTS];
   logic [31:0] sh_ticket [SLOTS];
   logic        sh_has [SLOTS];
   logic [39:0] sh_expiry [SLOTS];
   logic [48:0] sh_deadline [SLOTS];
   logic [47:0] sh_last [SLOTS];
   logic        sh_pending [SLOTS];
   logic [7:0]  sh_fails [SLOTS];
   logic [48:0] sh_retry [SLOTS];
   int          sh_count;

   etcb_req_type pending_items[$];
   etcb_rsp_type expected_rsps[$];
   int  mismatches = 0;
   longint cycles = 0;
   int  send_idle_pct = 0;
   bit  hold_send = 1'b0;
   logic [63:0] key_pool [16];

   function automatic int find_slot(logic [63:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (sh_used[i] && sh_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void evict_to(int lim);
      int best;
      while (sh_count > lim) begin
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (!sh_used[i] || sh_pending[i]) continue;
            if (best < 0 || sh_last[i] < sh_last[best]) best = i;
         end
         if (best < 0) return;
         sh_used[best] = 1'b0;
         sh_count--;
      end
   endfunction

   function automatic int claim_slot(logic [63:0] k);
      if (sh_count >= SLOTS) evict_to(CAP * 3 / 4 - 1);
      for (int i = 0; i < SLOTS; i++)
         if (!sh_used[i]) begin
            sh_used[i] = 1'b1; sh_key[i] = k; sh_ticket[i] = '0; sh_has[i] = 1'b0;
            sh_expiry[i] = '0; sh_deadline[i] = '0; sh_last[i] = '0;
            sh_pending[i] = 1'b0; sh_fails[i] = '0; sh_retry[i] = '0;
            sh_count++;
            return i;
         end
      return -1;
   endfunction

   // Computes the result of one item and advances the shadow state.
   function automatic etcb_rsp_type cache_answer(etcb_req_type it);
      etcb_rsp_type r;
      int s;
      logic [48:0] now, life, dl;
      logic [63:0] b;
      bit live, stale;
      r = '0;
      now = {1'b0, it.now_ms};
      life = it.lifetime_ms[31] ? 49'd0 : {17'd0, it.lifetime_ms};
      case (it.operation)
         OP_LOOKUP: if (cfg_server && it.key_well_formed) begin
            s = find_slot(it.object_key);
            if (s < 0) begin
               s = claim_slot(it.object_key);
               if (s >= 0) begin
                  sh_last[s] = it.now_ms; sh_pending[s] = 1'b1;
                  if (sh_count > CAP) evict_to(CAP * 3 / 4);
                  r.mint_request = 1'b1;
               end
            end else begin
               sh_last[s] = it.now_ms;
               dl = sh_deadline[s];
               live = sh_has[s] && now < dl;
               stale = live && ({1'b0, now} + cfg_margin >= {1'b0, dl});
               if ((!live || stale) && !sh_pending[s] && now >= sh_retry[s]) begin
                  sh_pending[s] = 1'b1;
                  r.mint_request = 1'b1;
               end
               if (live) begin
                  r.ticket_valid = 1'b1;
                  r.out_ticket_id = sh_ticket[s];
                  r.out_expiry_seconds = sh_expiry[s];
               end
            end
         end
         OP_STORE: begin
            s = find_slot(it.object_key);
            if (s < 0) s = claim_slot(it.object_key);
            if (s >= 0) begin
               sh_ticket[s] = it.ticket_id; sh_has[s] = it.ticket_present;
               sh_expiry[s] = it.expiry_seconds; sh_deadline[s] = now + life;
               sh_last[s] = it.now_ms; sh_pending[s] = 1'b0;
               sh_fails[s] = '0; sh_retry[s] = '0;
               if (sh_count > CAP) evict_to(CAP * 3 / 4);
               r.out_ticket_id = it.ticket_id;
               r.out_expiry_seconds = it.expiry_seconds;
               r.ticket_ready = it.ticket_present && cfg_server && it.key_well_formed;
            end
         end
         OP_FAIL: begin
            s = find_slot(it.object_key);
            if (s < 0) s = claim_slot(it.object_key);
            if (s >= 0) begin
               sh_pending[s] = 1'b0;
               if (sh_fails[s] < FAILURES_MAX) sh_fails[s]++;
               b = cfg_first;
               for (int i = 1; i < sh_fails[s] && b < cfg_max; i++) b = b * 2;
               if (b > cfg_max) b = cfg_max;
               sh_retry[s] = now + b[48:0];
               r.ticket_failed = 1'b1;
            end
         end
         OP_PROBE: begin
            s = find_slot(it.object_key);
            if (s >= 0 && sh_has[s] && now < sh_deadline[s]) r.live_now = 1'b1;
         end
         OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) sh_used[i] = 1'b0;
            sh_count = 0;
         end
         default: ;
      endcase
      r.entries_held = sh_count[8:0];
      return r;
   endfunction

   // Driver: one nonblocking update of start per edge.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !busy) && start) begin
         // Item still waiting for acceptance; hold it.
      end else if (!hold_send && pending_items.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
         req <= pending_items[0];
         expected_rsps.push_back(cache_answer(pending_items[0]));
         void'(pending_items.pop_front());
         start <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: the result is only shown for one cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp);
         end else begin
            if (rsp !== expected_rsps[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result differs: expected %p got %p", expected_rsps[0], rsp);
            end
            void'(expected_rsps.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("expiring_ticket_cache_with_backoff: mismatch");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SERVER_SET:     cfg_server = val[0];
         CSR_REFRESH_MARGIN: cfg_margin = val;
         CSR_FIRST_BACKOFF:  cfg_first = val;
         default:            cfg_max = val;
      endcase
   endtask

   // Waits for every queued item to be sent and answered, then lets the block settle.
   task automatic drain;
      while (pending_items.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (CAP + 20) @(posedge clock);
   endtask

   function automatic etcb_req_type make_item(etcb_op_type op, logic [63:0] k,
                                              logic [47:0] now, logic signed [31:0] life);
      etcb_req_type it;
      it = '0;
      it.operation = op; it.object_key = k; it.key_well_formed = 1'b1;
      it.now_ms = now; it.ticket_id = $urandom; it.ticket_present = 1'b1;
      it.expiry_seconds = {8'($urandom_range(255)), 32'($urandom)};
      it.lifetime_ms = life;
      return it;
   endfunction

   // Random item, mostly well-formed traffic on a small key pool around a moving clock.
   function automatic etcb_req_type random_item(logic [47:0] now);
      etcb_req_type it;
      int pick;
      pick = $urandom_range(99);
      it = make_item(etcb_op_type'(pick < 40 ? OP_LOOKUP : pick < 65 ? OP_STORE :
                     pick < 80 ? OP_FAIL : pick < 97 ? OP_PROBE : OP_CLEAR),
                     key_pool[$urandom_range(15)], now, $urandom_range(200000));
      if ($urandom_range(19) == 0) it.operation = 3'($urandom_range(7));
      if ($urandom_range(9) == 0) it.key_well_formed = 1'b0;
      if ($urandom_range(9) == 0) it.ticket_present = 1'b0;
      if ($urandom_range(9) == 0) it.object_key = {$urandom, $urandom};
      if ($urandom_range(15) == 0) it.lifetime_ms = $urandom;
      if ($urandom_range(31) == 0) it.now_ms = {16'($urandom), 32'($urandom)};
      return it;
   endfunction

   initial begin
      logic [47:0] now;
      for (int i = 0; i < SLOTS; i++) sh_used[i] = 1'b0;
      sh_count = 0;
      cfg_server = 1'b0; cfg_margin = REFRESH_MARGIN_RESET;
      cfg_first = FIRST_BACKOFF_RESET; cfg_max = MAX_BACKOFF_RESET;
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // Directed: lookup with no server, then the normal ticket life cycle.
      now = 48'd100000;
      pending_items.push_back(make_item(OP_LOOKUP, key_pool[0], now, 0));
      pending_items.push_back(make_item(OP_STORE, key_pool[0], now, 0));
      drain();
      write_reg(CSR_SERVER_SET, 32'd1);
      pending_items.push_back(make_item(OP_LOOKUP, '1, now, 0));
      pending_items.push_back(make_item(OP_LOOKUP, '0, now, 0));
      pending_items.push_back(make_item(OP_LOOKUP, key_pool[0], now, 0));
      pending_items.push_back(make_item(OP_STORE, key_pool[0], now, 100000));
      pending_items.push_back(make_item(OP_LOOKUP, key_pool[0], now + 1, 0));
      pending_items.push_back(make_item(OP_LOOKUP, key_pool[0], now + 50000, 0));
      pending_items.push_back(make_item(OP_PROBE, key_pool[0], now + 50000, 0));
      pending_items.push_back(make_item(OP_PROBE, key_pool[0], now + 100000, 0));
      pending_items.push_back(make_item(OP_STORE, '1, '1, 32'sh7fffffff));
      pending_items.push_back(make_item(OP_STORE, key_pool[1], now, -32'sd5));
      for (int i = 0; i < 4; i++)
         pending_items.push_back(make_item(OP_FAIL, key_pool[2], now, 0));
      pending_items.push_back(make_item(OP_LOOKUP, key_pool[2], now + 1000, 0));
      pending_items.push_back(make_item(OP_LOOKUP, key_pool[2], now + 9000, 0));
      pending_items.push_back(make_item(OP_FAIL, key_pool[3], now, 0));
      pending_items.push_back(make_item(OP_PROBE, 64'h0123, now, 0));
      pending_items.push_back(make_item(OP_CLEAR, 0, now, 0));
      pending_items.push_back(make_item(etcb_op_type'(3'd7), key_pool[0], now, 0));
      drain();

      // Failure count saturation and the backoff cap at its extremes.
      write_reg(CSR_FIRST_BACKOFF, 32'hFFFFFFFF);
      write_reg(CSR_MAX_BACKOFF, 32'd1);
      write_reg(CSR_REFRESH_MARGIN, 32'hFFFFFFFF);
      for (int i = 0; i < 260; i++)
         pending_items.push_back(make_item(OP_FAIL, key_pool[4], 48'($urandom), 0));
      drain();
      write_reg(CSR_FIRST_BACKOFF, 32'd1);
      write_reg(CSR_MAX_BACKOFF, 32'hFFFFFFFF);
      write_reg(CSR_REFRESH_MARGIN, 32'd0);
      for (int i = 0; i < 40; i++)
         pending_items.push_back(make_item(OP_FAIL, key_pool[5], now, 0));
      drain();

      // Overflow the table: new keys with lookups (in flight) and stores, then a full table.
      pending_items.push_back(make_item(OP_CLEAR, 0, now, 0));
      for (int i = 0; i < 300; i++)
         pending_items.push_back(make_item(i % 3 == 0 ? OP_LOOKUP : OP_STORE,
                                           64'(i) + 64'h1000, 48'($urandom_range(50)), 1000));
      drain();
      for (int i = 0; i < 270; i++)
         pending_items.push_back(make_item(OP_LOOKUP, 64'(i) + 64'h9000, now, 0));
      pending_items.push_back(make_item(OP_FAIL, 64'h7777, now, 0));
      pending_items.push_back(make_item(OP_STORE, 64'h7778, now, 0));
      pending_items.push_back(make_item(OP_CLEAR, 0, now, 0));
      drain();

      // Random phases over several register settings and idle patterns.
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_SERVER_SET, ph == 3 ? 32'd0 : 32'd1);
         write_reg(CSR_REFRESH_MARGIN, $urandom_range(100000));
         write_reg(CSR_FIRST_BACKOFF, $urandom_range(1, 5000));
         write_reg(CSR_MAX_BACKOFF, $urandom_range(1, 400000));
         send_idle_pct = (ph == 1) ? 51 : (ph == 2) ? 11 : 0;
         for (int i = 0; i < 75; i++) begin
            now = now + 48'($urandom_range(30000));
            pending_items.push_back(random_item(now));
            if (i == 37) begin
               // Pause until everything sent so far has been answered.
               hold_send = 1'b0;
               while (pending_items.size() > 0 || start || expected_rsps.size() > 0)
                  @(posedge clock);
               hold_send = 1'b1;
               repeat (5) @(posedge clock);
               hold_send = 1'b0;
            end
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("expiring_ticket_cache_with_backoff: match");
      end else begin
         $display("expiring_ticket_cache_with_backoff: mismatch");
      end
      $finish;
   end
endmodule
